>>> rtl/wheel_to_touch_gesture_unit_macros.svh
// Assertion macros shared by the wheel-to-touch gesture RTL.
`ifndef WHEEL_TO_TOUCH_GESTURE_UNIT_MACROS_SVH
`define WHEEL_TO_TOUCH_GESTURE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define WTG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wtg: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define WTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wtg: next-cycle check failed");
`else
`define WTG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WTG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/wtg_pkg.sv
// Types and constants shared by the wheel-to-touch gesture unit.
package wtg_pkg;

    localparam int DELTA_W    = 16;
    localparam int TIME_W     = 32;
    localparam int Y_W        = 12;
    localparam int POS_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int REP_IDX_W  = 2;
    localparam int REP_CNT_W  = 3;
    localparam int MAX_REPORTS = 4;

    localparam logic [Y_W-1:0] PAD_MAX = 12'd4095;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_THRESHOLD = 3'd0,
        CFG_FILTER_WINDOW   = 3'd1,
        CFG_RELEASE         = 3'd2,
        CFG_EDGE_MARGIN     = 3'd3,
        CFG_CENTER_Y        = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [14:0] start_threshold;
        logic [15:0] filter_window_ms;
        logic [15:0] release_ms;
        logic [10:0] edge_margin;
        logic [11:0] center_y;
    } cfg_t;

    localparam logic [14:0] RST_START_THRESHOLD = 15'd4;
    localparam logic [15:0] RST_FILTER_WINDOW   = 16'd25;
    localparam logic [15:0] RST_RELEASE         = 16'd80;
    localparam logic [10:0] RST_EDGE_MARGIN     = 11'd384;
    localparam logic [11:0] RST_CENTER_Y        = 12'd2048;

    typedef struct packed {
        logic           fingers_down;
        logic [Y_W-1:0] finger_y;
    } report_t;

    // All reports caused by one poll, in order, with their count.
    typedef struct packed {
        report_t [MAX_REPORTS-1:0] rep;
        logic [REP_CNT_W-1:0]      count;
    } bundle_t;

endpackage

>>> rtl/wtg_ifs.sv
// Valid/ready channel interfaces for polls and touch reports.
interface wtg_poll_if;
    logic                                valid;
    logic                                ready;
    logic signed [wtg_pkg::DELTA_W-1:0]  scroll_delta;
    logic                                enabled;
    logic [wtg_pkg::TIME_W-1:0]          now_ms;

    modport source (output valid, scroll_delta, enabled, now_ms, input ready);
    modport sink (input valid, scroll_delta, enabled, now_ms, output ready);
endinterface

interface wtg_report_if;
    logic                        valid;
    logic                        ready;
    logic                        fingers_down;
    logic [wtg_pkg::Y_W-1:0]     finger_y;
    logic                        last;

    modport source (output valid, fingers_down, finger_y, last, input ready);
    modport sink (input valid, fingers_down, finger_y, last, output ready);
endinterface

>>> rtl/wtg_cfg_regs.sv
// Configuration register file with reset values and field masking.
module wtg_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [wtg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wtg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output wtg_pkg::cfg_t                    cfg
);

    wtg_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_threshold  <= wtg_pkg::RST_START_THRESHOLD;
            cfg_reg.filter_window_ms <= wtg_pkg::RST_FILTER_WINDOW;
            cfg_reg.release_ms       <= wtg_pkg::RST_RELEASE;
            cfg_reg.edge_margin      <= wtg_pkg::RST_EDGE_MARGIN;
            cfg_reg.center_y         <= wtg_pkg::RST_CENTER_Y;
        end
        else if (cfg_wr_en)
        begin
            case (wtg_pkg::cfg_index_t'(cfg_index))
                wtg_pkg::CFG_START_THRESHOLD: cfg_reg.start_threshold  <= cfg_wdata[14:0];
                wtg_pkg::CFG_FILTER_WINDOW:   cfg_reg.filter_window_ms <= cfg_wdata;
                wtg_pkg::CFG_RELEASE:         cfg_reg.release_ms       <= cfg_wdata;
                wtg_pkg::CFG_EDGE_MARGIN:     cfg_reg.edge_margin      <= cfg_wdata[10:0];
                wtg_pkg::CFG_CENTER_Y:        cfg_reg.center_y         <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/wtg_engine.sv
// Poll input register, gesture state and the single-pass step logic.
`include "wheel_to_touch_gesture_unit_macros.svh"

module wtg_engine
(
    input  logic              clk,
    input  logic              rst_n,
    wtg_poll_if.sink          poll,
    input  wtg_pkg::cfg_t     cfg,
    input  logic              bundle_ready,
    output wtg_pkg::bundle_t  bundle,
    output logic              bundle_load
);

    // Input register.
    logic                                in_valid_reg;
    logic signed [wtg_pkg::DELTA_W-1:0]  in_delta_reg;
    logic                                in_en_reg;
    logic [wtg_pkg::TIME_W-1:0]          in_now_reg;

    // Gesture state.
    logic                                touch_on_reg,  touch_next;
    logic signed [wtg_pkg::POS_W-1:0]    pos_y_reg,     pos_next;
    logic [wtg_pkg::DELTA_W-1:0]         pend_reg,      pend_next;
    logic [wtg_pkg::TIME_W-1:0]          win_start_reg, win_start_next;
    logic [wtg_pkg::TIME_W-1:0]          motion_reg,    motion_next;

    logic                                fire;
    logic [wtg_pkg::DELTA_W-1:0]         psum;
    logic [wtg_pkg::DELTA_W-1:0]         mag;
    logic                                hit;
    logic                                expire;
    logic                                move;
    logic [wtg_pkg::TIME_W-1:0]          ws_eff;
    logic [wtg_pkg::TIME_W-1:0]          win_el;
    logic [wtg_pkg::TIME_W-1:0]          mot_el;
    logic [wtg_pkg::TIME_W-1:0]          motion_after;
    logic signed [wtg_pkg::POS_W-1:0]    center_pos;
    logic signed [wtg_pkg::POS_W-1:0]    base;
    logic signed [wtg_pkg::POS_W-1:0]    pos_new;
    logic signed [wtg_pkg::POS_W-1:0]    pos_after;
    logic signed [wtg_pkg::POS_W:0]      sum1;
    logic signed [wtg_pkg::POS_W:0]      sum2;
    logic signed [wtg_pkg::POS_W:0]      lo_ext;
    logic signed [wtg_pkg::POS_W:0]      hi_ext;
    logic [wtg_pkg::Y_W-1:0]             hi_y;
    logic                                out_band;
    logic                                touch_after;
    logic                                timeout;
    logic [wtg_pkg::REP_CNT_W-1:0]       idx;
    wtg_pkg::bundle_t                    bundle_next;

    function automatic logic [wtg_pkg::Y_W-1:0] clamp_y(
        input logic signed [wtg_pkg::POS_W-1:0] v);
        logic [wtg_pkg::Y_W-1:0] r;
        if (v[wtg_pkg::POS_W-1])
            r = '0;
        else if (|v[wtg_pkg::POS_W-2:wtg_pkg::Y_W])
            r = wtg_pkg::PAD_MAX;
        else
            r = v[wtg_pkg::Y_W-1:0];
        return r;
    endfunction

    function automatic wtg_pkg::report_t make_rep(input logic down,
                                                  input logic [wtg_pkg::Y_W-1:0] y);
        wtg_pkg::report_t r;
        r.fingers_down = down;
        r.finger_y     = y;
        return r;
    endfunction

    assign fire       = in_valid_reg & bundle_ready;
    assign poll.ready = ~in_valid_reg | fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (poll.ready)
            in_valid_reg <= poll.valid;
    end

    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            in_delta_reg <= poll.scroll_delta;
            in_en_reg    <= poll.enabled;
            in_now_reg   <= poll.now_ms;
        end
    end

    // Pending sum and threshold / window tests.
    assign psum   = pend_reg + $unsigned(in_delta_reg);
    assign mag    = psum[wtg_pkg::DELTA_W-1] ? (16'd0 - psum) : psum;
    assign hit    = mag >= {1'b0, cfg.start_threshold};
    assign ws_eff = (win_start_reg == '0) ? in_now_reg : win_start_reg;
    assign win_el = (win_start_reg == '0) ? '0 : (in_now_reg - win_start_reg);
    assign expire = win_el >= {16'd0, cfg.filter_window_ms};
    assign move   = hit && (psum != '0);

    // Position update and edge band test.
    assign center_pos = {5'd0, cfg.center_y};
    assign base       = touch_on_reg ? pos_y_reg : center_pos;
    assign sum1       = {base[wtg_pkg::POS_W-1], base} + {{2{psum[15]}}, psum};
    assign sum2       = {6'd0, cfg.center_y} + {{2{psum[15]}}, psum};
    assign hi_y       = wtg_pkg::PAD_MAX - {1'b0, cfg.edge_margin};
    assign lo_ext     = {7'd0, cfg.edge_margin};
    assign hi_ext     = {6'd0, hi_y};
    assign out_band   = (sum1 < lo_ext) || (sum1 > hi_ext);
    assign pos_new    = out_band ? sum2[wtg_pkg::POS_W-1:0] : sum1[wtg_pkg::POS_W-1:0];

    always_comb
    begin
        touch_next     = touch_on_reg;
        pos_next       = pos_y_reg;
        pend_next      = pend_reg;
        win_start_next = win_start_reg;
        motion_next    = motion_reg;
        pos_after      = pos_y_reg;
        motion_after   = motion_reg;
        touch_after    = 1'b0;
        mot_el         = '0;
        timeout        = 1'b0;
        bundle_next    = '0;
        idx            = '0;

        if (!in_en_reg)
        begin
            if (touch_on_reg)
            begin
                bundle_next.rep[idx[wtg_pkg::REP_IDX_W-1:0]] = make_rep(1'b0, clamp_y(pos_y_reg));
                idx = idx + 3'd1;
            end
            touch_next     = 1'b0;
            pos_next       = center_pos;
            pend_next      = '0;
            win_start_next = '0;
            motion_next    = '0;
        end
        else
        begin
            pend_next      = (hit || expire) ? '0 : psum;
            win_start_next = (hit || expire) ? in_now_reg : ws_eff;

            if (move)
            begin
                if (!touch_on_reg)
                begin
                    bundle_next.rep[idx[wtg_pkg::REP_IDX_W-1:0]] = make_rep(1'b1, cfg.center_y);
                    idx = idx + 3'd1;
                end
                if (out_band)
                begin
                    bundle_next.rep[idx[wtg_pkg::REP_IDX_W-1:0]] = make_rep(1'b0, clamp_y(base));
                    idx = idx + 3'd1;
                    bundle_next.rep[idx[wtg_pkg::REP_IDX_W-1:0]] = make_rep(1'b1, cfg.center_y);
                    idx = idx + 3'd1;
                end
                pos_after    = pos_new;
                motion_after = in_now_reg;
            end

            touch_after = touch_on_reg | move;
            mot_el      = move ? '0 : (in_now_reg - motion_reg);
            timeout     = (motion_after != '0) && (mot_el >= {16'd0, cfg.release_ms});

            if (touch_after)
            begin
                if (timeout)
                begin
                    bundle_next.rep[idx[wtg_pkg::REP_IDX_W-1:0]] =
                        make_rep(1'b0, clamp_y(pos_after));
                    idx = idx + 3'd1;
                    touch_next     = 1'b0;
                    pos_next       = center_pos;
                    pend_next      = '0;
                    win_start_next = '0;
                    motion_next    = '0;
                end
                else
                begin
                    bundle_next.rep[idx[wtg_pkg::REP_IDX_W-1:0]] =
                        make_rep(1'b1, clamp_y(pos_after));
                    idx = idx + 3'd1;
                    touch_next  = 1'b1;
                    pos_next    = pos_after;
                    motion_next = motion_after;
                end
            end
        end

        bundle_next.count = idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_on_reg  <= 1'b0;
            pos_y_reg     <= {5'd0, wtg_pkg::RST_CENTER_Y};
            pend_reg      <= '0;
            win_start_reg <= '0;
            motion_reg    <= '0;
        end
        else if (fire)
        begin
            touch_on_reg  <= touch_next;
            pos_y_reg     <= pos_next;
            pend_reg      <= pend_next;
            win_start_reg <= win_start_next;
            motion_reg    <= motion_next;
        end
    end

    assign bundle      = bundle_next;
    assign bundle_load = fire && (bundle_next.count != '0);

    `WTG_ASSERT_NEXT(a_disable_drops, clk, rst_n, fire && !in_en_reg, !touch_on_reg)
    `WTG_ASSERT_IMP(a_idle_no_motion, clk, rst_n, !touch_on_reg, motion_reg == '0)
    `WTG_ASSERT_IMP(a_active_reports, clk, rst_n, fire && in_en_reg && touch_after, bundle_load)

endmodule

>>> rtl/wtg_report_ser.sv
// Result register for one poll's reports, sent out one transfer per cycle while ready is high.
`include "wheel_to_touch_gesture_unit_macros.svh"

module wtg_report_ser
(
    input  logic              clk,
    input  logic              rst_n,
    input  wtg_pkg::bundle_t  bundle,
    input  logic              bundle_load,
    output logic              bundle_ready,
    wtg_report_if.source      report
);

    wtg_pkg::bundle_t                  bundle_reg;
    logic                              busy_reg;
    logic [wtg_pkg::REP_IDX_W-1:0]     idx_reg;
    logic [wtg_pkg::REP_CNT_W-1:0]     idx_ext;
    logic                              last_item;
    logic                              xfer;

    assign idx_ext      = {1'b0, idx_reg};
    assign last_item    = (idx_ext + 3'd1) == bundle_reg.count;
    assign xfer         = busy_reg & report.ready;
    assign bundle_ready = ~busy_reg | (report.ready & last_item);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (bundle_load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (xfer)
        begin
            if (last_item)
                busy_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bundle_load)
            bundle_reg <= bundle;
    end

    assign report.valid        = busy_reg;
    assign report.fingers_down = bundle_reg.rep[idx_reg].fingers_down;
    assign report.finger_y     = bundle_reg.rep[idx_reg].finger_y;
    assign report.last         = last_item;

    `WTG_ASSERT_IMP(a_load_free, clk, rst_n, bundle_load, !busy_reg || (report.ready && last_item))
    `WTG_ASSERT_IMP(a_idx_range, clk, rst_n, busy_reg, idx_ext < bundle_reg.count)
    `WTG_ASSERT_NEXT(a_fresh_bundle, clk, rst_n, bundle_load, busy_reg && (idx_reg == '0))

endmodule

>>> rtl/wheel_to_touch_gesture_unit.sv
// Timing: a poll waits in the engine's input register and is evaluated there; its reports
// are loaded into the serializer's result register and offered one per cycle while the
// receiver is ready. Throughput: one poll per cycle while each poll yields at most one report
// and the receiver is ready; a poll with n reports (0 to 4) keeps the port until all are sent.
// Reset (rst_n, asynchronous, active low) clears the channels, drops any touch, recenters Y
// to 2048 and loads all configuration registers with their reset values.
module wheel_to_touch_gesture_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    wtg_poll_if.sink                         poll,
    wtg_report_if.source                     report,
    input  logic                             cfg_wr_en,
    input  logic [wtg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wtg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    // The block has three parts. The register file holds the five settings. The engine
    // keeps one poll in its input register and, in a single pass of logic, updates the
    // wheel accumulator, the filter window, the virtual Y position and the idle timer,
    // and builds the ordered list of reports (press, release, press, final) that the
    // poll causes. That list is the result register of the serializer, which offers the
    // reports one transfer per cycle while the receiver is ready and marks the final one with last.
    //
    // The engine takes the next poll as soon as the serializer can accept a new list,
    // which is in the same cycle as the final report of the previous list is transferred.
    // Polls that cause no report update the state and produce no transfer at all.

    wtg_pkg::cfg_t     cfg;
    wtg_pkg::bundle_t  bundle;
    logic              bundle_load;
    logic              bundle_ready;

    wtg_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Change settings only while the block is idle (unenforced); the engine reads them directly.
    wtg_engine u_engine
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll         (poll),
        .cfg          (cfg),
        .bundle_ready (bundle_ready),
        .bundle       (bundle),
        .bundle_load  (bundle_load)
    );

    wtg_report_ser u_ser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .bundle       (bundle),
        .bundle_load  (bundle_load),
        .bundle_ready (bundle_ready),
        .report       (report)
    );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the wheel-to-touch gesture unit.
`timescale 1ns / 100ps

module tb;

    import wtg_pkg::*;

    // The watchdog ends the run after this many cycles without any transfer. The longest
    // quiet stretch of a correct run is the receiver hold-off.
    localparam int STALL_LIMIT = 4000;

    // A poll can yield no report, so before a register write the block gets this many
    // extra cycles to finish evaluating whatever it accepted last.
    localparam int SETTLE_CYCLES = 8;

    // The receiver hold-off used to fill the block and stall its poll input.
    localparam int HOLD_OFF_CYCLES = 300;

    // One report as the block should present it.
    typedef struct {
        bit             down;
        logic [Y_W-1:0] y;
        bit             fin;
    } touch_report_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    wtg_poll_if   poll_ch ();
    wtg_report_if report_ch ();

    wheel_to_touch_gesture_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .poll      (poll_ch),
        .report    (report_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Our own copy of the register file, kept in step with every write.
    logic [14:0] cfg_thr;
    logic [15:0] cfg_window;
    logic [15:0] cfg_release;
    logic [10:0] cfg_margin;
    logic [11:0] cfg_center;

    // Gesture state as the block should hold it. A time of zero means unset.
    bit                 touch_held;
    int                 finger_pos;
    logic [DELTA_W-1:0] drift_sum;
    logic [TIME_W-1:0]  window_t0;
    logic [TIME_W-1:0]  last_motion_t;

    // Reports of the poll being evaluated, and all reports still owed by the block.
    touch_report_t poll_out[$];
    touch_report_t pending_reports[$];

    // Traffic shaping: percentages of idle cycles on each side, and a hold-off counter
    // that the receiver process counts down on its own.
    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold_cycles;

    int polls_sent;
    int reports_seen;
    int reg_writes;
    int mismatches;

    // Millisecond clock carried by the random polls.
    logic [TIME_W-1:0] clock_ms;

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------------------
    // Gesture predictor
    // ------------------------------------------------------------------------------------

    function automatic logic [Y_W-1:0] clamp_pad(int v);
        if (v < 0)
            return '0;
        if (v > int'(PAD_MAX))
            return PAD_MAX;
        return v[Y_W-1:0];
    endfunction

    // The block never emits more than four reports for one poll.
    function automatic void queue_report(bit down);
        touch_report_t r;
        if (poll_out.size() < MAX_REPORTS)
        begin
            r.down = down;
            r.y    = clamp_pad(finger_pos);
            r.fin  = 1'b0;
            poll_out.push_back(r);
        end
    endfunction

    // Lifting the fingers reports the position held before everything is recentered.
    function automatic void lift_touch();
        if (touch_held)
            queue_report(1'b0);
        touch_held    = 1'b0;
        drift_sum     = '0;
        window_t0     = '0;
        last_motion_t = '0;
        finger_pos    = int'(cfg_center);
    endfunction

    // Works out the reports of one accepted poll and appends them to pending_reports.
    function automatic void advance_gesture(logic signed [DELTA_W-1:0] delta, logic en,
                                            logic [TIME_W-1:0] now);
        int                sum_val;
        int                mag;
        int                moved;
        int                nxt;
        int                lo;
        int                hi;
        logic [TIME_W-1:0] elapsed;
        touch_report_t     r;
        poll_out.delete();
        moved = 0;
        if (!en)
            lift_touch();
        else
        begin
            if (window_t0 == '0)
                window_t0 = now;
            drift_sum = drift_sum + delta;
            // The magnitude of the most negative sum is 32768, which needs the wide int.
            sum_val = $signed(drift_sum);
            mag     = (sum_val < 0) ? -sum_val : sum_val;
            elapsed = now - window_t0;
            if (mag >= int'(cfg_thr))
            begin
                moved     = sum_val;
                drift_sum = '0;
                window_t0 = now;
            end
            else if (elapsed >= {16'd0, cfg_window})
            begin
                drift_sum = '0;
                window_t0 = now;
            end
            if (moved != 0)
            begin
                lo = int'(cfg_margin);
                hi = int'(PAD_MAX) - lo;
                if (!touch_held)
                begin
                    touch_held = 1'b1;
                    finger_pos = int'(cfg_center);
                    queue_report(1'b1);
                end
                nxt = finger_pos + moved;
                // Leaving the band lifts the fingers, recenters and presses again before
                // the motion is applied from the center.
                if (nxt < lo || nxt > hi)
                begin
                    queue_report(1'b0);
                    finger_pos = int'(cfg_center);
                    queue_report(1'b1);
                    nxt = finger_pos + moved;
                end
                finger_pos    = nxt;
                last_motion_t = now;
            end
            if (touch_held)
            begin
                elapsed = now - last_motion_t;
                // Motion taken at time zero leaves the idle timer unset until the next motion.
                if (last_motion_t != '0 && elapsed >= {16'd0, cfg_release})
                    lift_touch();
                else
                    queue_report(1'b1);
            end
        end
        if (poll_out.size() > 0)
        begin
            r     = poll_out.pop_back();
            r.fin = 1'b1;
            poll_out.push_back(r);
        end
        foreach (poll_out[i])
            pending_reports.push_back(poll_out[i]);
    endfunction

    // ------------------------------------------------------------------------------------
    // Report checking
    // ------------------------------------------------------------------------------------

    function automatic void flag_error(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endfunction

    // Every report transfer is matched against the oldest report still owed.
    always @(posedge clk)
    begin : check_reports
        touch_report_t want;
        if (rst_n && report_ch.valid && report_ch.ready)
        begin
            reports_seen++;
            if (pending_reports.size() == 0)
                flag_error($sformatf("unexpected report down=%0b y=%0d last=%0b",
                                     report_ch.fingers_down, report_ch.finger_y,
                                     report_ch.last));
            else
            begin
                want = pending_reports.pop_front();
                if (report_ch.fingers_down !== want.down || report_ch.finger_y !== want.y
                    || report_ch.last !== want.fin)
                    flag_error($sformatf("want down=%0b y=%0d last=%0b, %s",
                                         want.down, want.y, want.fin,
                                         $sformatf("got down=%0b y=%0d last=%0b",
                                                   report_ch.fingers_down,
                                                   report_ch.finger_y, report_ch.last)));
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Receiver: random stalls, or a solid hold-off while recv_hold_cycles runs down.
    // ------------------------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (recv_hold_cycles > 0)
        begin
            recv_hold_cycles = recv_hold_cycles - 1;
            report_ch.ready <= 1'b0;
        end
        else
            report_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------------------
    // Watchdog: a run that stops moving is a failure.
    // ------------------------------------------------------------------------------------

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (poll_ch.valid && poll_ch.ready)
                || (report_ch.valid && report_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Stimulus helpers. Every task is entered and left just after a falling edge.
    // ------------------------------------------------------------------------------------

    // Offers one poll, with random idle cycles ahead of it, and waits for its transfer.
    // Valid stays high afterwards so that back-to-back polls need no extra edge.
    task automatic send_poll(logic signed [DELTA_W-1:0] delta, logic en,
                             logic [TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            poll_ch.valid <= 1'b0;
            @(negedge clk);
        end
        poll_ch.valid        <= 1'b1;
        poll_ch.scroll_delta <= delta;
        poll_ch.enabled      <= en;
        poll_ch.now_ms       <= now;
        do
            @(posedge clk);
        while (!poll_ch.ready);
        advance_gesture(delta, en, now);
        polls_sent++;
        @(negedge clk);
    endtask

    // Drops valid and waits until the block owes nothing and has finished its last poll.
    task automatic settle();
        poll_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_START_THRESHOLD: cfg_thr     = value[14:0];
            CFG_FILTER_WINDOW:   cfg_window  = value[15:0];
            CFG_RELEASE:         cfg_release = value[15:0];
            CFG_EDGE_MARGIN:     cfg_margin  = value[10:0];
            CFG_CENTER_Y:        cfg_center  = value[11:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Registers only change while the block is idle.
    task automatic apply_config(int unsigned thr, int unsigned win, int unsigned rel,
                                int unsigned margin, int unsigned center);
        settle();
        write_reg(CFG_START_THRESHOLD, thr);
        write_reg(CFG_FILTER_WINDOW, win);
        write_reg(CFG_RELEASE, rel);
        write_reg(CFG_EDGE_MARGIN, margin);
        write_reg(CFG_CENTER_Y, center);
    endtask

    // Mostly small, practical settings, with the occasional value anywhere in range.
    task automatic random_config();
        int unsigned thr;
        int unsigned win;
        int unsigned rel;
        int unsigned margin;
        thr    = ($urandom_range(9) == 0) ? $urandom_range(32767, 1) : $urandom_range(40, 1);
        win    = ($urandom_range(9) == 0) ? $urandom_range(65535, 1) : $urandom_range(60, 1);
        rel    = ($urandom_range(9) == 0) ? $urandom_range(65535, 1) : $urandom_range(300, 20);
        margin = ($urandom_range(4) == 0) ? $urandom_range(2047, 0) : $urandom_range(600, 0);
        apply_config(thr, win, rel, margin, $urandom_range(4095, 0));
    endtask

    // One poll of a plausible scroll gesture most of the time: small deltas near the
    // threshold and a few milliseconds between polls. The rest are pauses around the release
    // time, full-range deltas, disables, time jumps, polls at time zero and zero-delta polls.
    task automatic send_random_poll();
        int                        pick;
        int                        span;
        int                        rel;
        logic signed [DELTA_W-1:0] d;
        logic                      en;
        pick = $urandom_range(99);
        span = (cfg_thr > 15'd4000) ? 8000 : 2 * int'(cfg_thr) + 3;
        rel  = int'(cfg_release);
        d    = DELTA_W'(int'($urandom_range(2 * span, 0)) - span);
        en   = 1'b1;
        if (pick < 70)
            clock_ms += $urandom_range(12, 1);
        else if (pick < 78)
            clock_ms += $urandom_range(2 * rel, rel / 2);
        else if (pick < 84)
        begin
            d = DELTA_W'($urandom());
            clock_ms += $urandom_range(12, 1);
        end
        else if (pick < 89)
        begin
            en = 1'b0;
            clock_ms += $urandom_range(12, 1);
        end
        else if (pick < 94)
            clock_ms = $urandom();
        else if (pick < 97)
            clock_ms = '0;
        else
        begin
            d = '0;
            clock_ms += $urandom_range(3, 1);
        end
        send_poll(d, en, clock_ms);
    endtask

    // ------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------

    // Hand-picked polls at the reset settings: drift filtering, start of a touch, both
    // delta extremes with recentering and clamping, idle and disable releases, the zero
    // time marker and a wrap of the millisecond counter.
    task automatic test_directed();
        send_poll(16'sd0, 1'b0, 32'd100);            // disabled with no touch: silent
        send_poll(16'sd1, 1'b1, 32'd100);            // drift below threshold
        send_poll(16'sd1, 1'b1, 32'd110);
        send_poll(16'sd1, 1'b1, 32'd130);            // window runs out, drift dropped
        send_poll(16'sd5, 1'b1, 32'd140);            // touch starts
        send_poll(16'sd32767, 1'b1, 32'd150);        // recenter, Y clamped high
        send_poll(-16'sd32768, 1'b1, 32'd160);
        send_poll(-16'sd3, 1'b1, 32'd170);           // below threshold, touch held
        send_poll(16'sd0, 1'b1, 32'd240);            // idle timeout releases
        send_poll(16'sd0, 1'b1, 32'd250);            // nothing active: no report
        send_poll(-16'sd2047, 1'b1, 32'd260);        // start then recenter downward
        send_poll(16'sd0, 1'b0, 32'd270);            // disable releases the touch
        send_poll(16'sd1, 1'b1, 32'd0);              // window opened at time zero
        send_poll(16'sd1, 1'b1, 32'd5);              // so it restarts here
        send_poll(16'sd8, 1'b1, 32'd0);              // motion at time zero
        send_poll(16'sd0, 1'b1, 32'd5000);           // never times out
        send_poll(16'sd0, 1'b0, 32'd5001);
        send_poll(16'sd20, 1'b1, 32'hFFFF_FFFF);     // touch just before the wrap
        send_poll(16'sd0, 1'b1, 32'h0000_002F);      // 48 ms later: held
        send_poll(16'sd0, 1'b1, 32'h0000_004F);      // 80 ms later: released
    endtask

    // Every register at the top of its range, then margin and center at zero and the rest at one.
    task automatic test_extreme_settings();
        // Largest threshold: only sums of magnitude 32767 or more get through, and with the widest
        // margin every motion recenters.
        apply_config(32767, 65535, 65535, 2047, 4095);
        send_poll(-16'sd16384, 1'b1, 32'd1000);
        send_poll(-16'sd16384, 1'b1, 32'd1001);
        send_poll(16'sd1, 1'b1, 32'd1002);
        clock_ms = 32'd2000;
        repeat (10) send_random_poll();
        // Smallest settings: any motion counts and one millisecond of rest releases.
        apply_config(1, 1, 1, 0, 0);
        repeat (12) send_random_poll();
    endtask

    // Random gestures, with fresh settings at the start and halfway through each traffic mode.
    task automatic test_random_gestures();
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 25;
                    recv_idle_pct = 49;
                end
                1:
                begin
                    send_idle_pct = 49;
                    recv_idle_pct = 25;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (2)
            begin
                random_config();
                clock_ms = $urandom();
                repeat (50) send_random_poll();
            end
        end
    endtask

    // Keeps a touch alive so that each poll yields a report, then holds the receiver off
    // while polls keep coming: the block has to fill up and stop taking polls.
    task automatic test_backpressure();
        logic [TIME_W-1:0] t;
        apply_config(4, 25, 2000, 384, 2048);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        t = 32'd7000;
        send_poll(16'sd10, 1'b1, t);
        recv_hold_cycles = HOLD_OFF_CYCLES;
        for (int i = 0; i < 40; i++)
        begin
            t = t + 1;
            send_poll((i % 2 == 0) ? -16'sd6 : 16'sd7, 1'b1, t);
        end
        settle();
    endtask

    // ------------------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------------------

    initial
    begin
        rst_n                = 1'b0;
        poll_ch.valid        = 1'b0;
        poll_ch.scroll_delta = '0;
        poll_ch.enabled      = 1'b0;
        poll_ch.now_ms       = '0;
        report_ch.ready      = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = CFG_START_THRESHOLD;
        cfg_wdata            = '0;
        send_idle_pct        = 25;
        recv_idle_pct        = 49;
        recv_hold_cycles     = 0;
        polls_sent           = 0;
        reports_seen         = 0;
        reg_writes           = 0;
        mismatches           = 0;
        clock_ms             = '0;

        // Predictor state after reset.
        cfg_thr       = RST_START_THRESHOLD;
        cfg_window    = RST_FILTER_WINDOW;
        cfg_release   = RST_RELEASE;
        cfg_margin    = RST_EDGE_MARGIN;
        cfg_center    = RST_CENTER_Y;
        touch_held    = 1'b0;
        finger_pos    = int'(RST_CENTER_Y);
        drift_sum     = '0;
        window_t0     = '0;
        last_motion_t = '0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_extreme_settings();
        test_random_gestures();
        test_backpressure();
        settle();

        $display("run: %0d polls, %0d reports checked, %0d register writes",
                 polls_sent, reports_seen, reg_writes);
        $display("run: recentering, clamping, idle and disable releases, zero and wrapped %s",
                 "times, extreme settings and a long receiver hold-off");
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
